[hdl/gnfs_pkg.sv]
// Shared types and constants for the nearest free node snap core.
`default_nettype none
package gnfs_pkg;
	localparam int MaxNodes = 1024;
	localparam int CoordBits = 16;
	localparam int IdxBits = $clog2(MaxNodes);
	localparam int CountBits = 11;
	localparam int DiffBits = CoordBits + 1;
	localparam int SqBits = 2 * DiffBits;
	localparam int DistBits = SqBits + 2;
	localparam int QDepth = 2;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_SNAP  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		action_t                      action;
		logic [IdxBits-1:0]           entry;
		logic signed [CoordBits-1:0]  x;
		logic signed [CoordBits-1:0]  y;
		logic signed [CoordBits-1:0]  z;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_DRAIN,
		ST_MARK,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

[hdl/gnfs_front.sv]
// Front end: accepts input transfers, drops unknown actions, queues commands.
`default_nettype none
module gnfs_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire gnfs_pkg::cmd_t in_cmd,
	output logic                q_valid,
	input  wire                 q_ready,
	output gnfs_pkg::cmd_t      q_cmd
);
	import gnfs_pkg::*;

	localparam int PtrBits = $clog2(QDepth);

	cmd_t               mem_q [QDepth];
	logic [PtrBits-1:0] wr_q, rd_q;
	logic [PtrBits:0]   cnt_q;
	logic               push, pop;

	assign in_ready = (cnt_q != (PtrBits+1)'(QDepth));
	assign push     = in_valid && in_ready && (in_cmd.action != ACT_NONE);
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_valid && q_ready;
	assign q_cmd    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
		end
	end
endmodule
`default_nettype wire

[hdl/gnfs_back.sv]
// Back end: node table, used marks and the sequential nearest node scan.
`default_nettype none
module gnfs_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire [gnfs_pkg::CountBits-1:0]    node_count,
	input  wire                              q_valid,
	output logic                             q_ready,
	input  wire gnfs_pkg::cmd_t              q_cmd,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [gnfs_pkg::IdxBits-1:0]     out_index,
	output logic                             out_status
);
	import gnfs_pkg::*;

	logic signed [CoordBits-1:0] xs [MaxNodes];
	logic signed [CoordBits-1:0] ys [MaxNodes];
	logic signed [CoordBits-1:0] zs [MaxNodes];
	logic                        used_mem [MaxNodes];

	state_t                 state_q, state_d;
	cmd_t                   cmd_q;
	logic [IdxBits:0]       ptr_q;
	logic [IdxBits:0]       limit;
	logic                   take;

	// stage 1: table read, stage 2: squares, stage 3: sum and compare
	logic                        v_s1, v_s2;
	logic [IdxBits-1:0]          i_s1, i_s2;
	logic                        u_s1, u_s2;
	logic signed [CoordBits-1:0] x_s1, y_s1, z_s1;
	logic [SqBits-1:0]           sx_s2, sy_s2, sz_s2;
	logic [DistBits-1:0]         dist_sum, best_q;
	logic [IdxBits-1:0]          best_i_q;
	logic                        found_q;
	logic signed [DiffBits-1:0]  dx, dy, dz;
	logic [DiffBits-1:0]         ax, ay, az;

	assign limit = (node_count > CountBits'(MaxNodes)) ? (IdxBits+1)'(MaxNodes)
		: (IdxBits+1)'(node_count);
	assign take = (state_q == ST_IDLE) && q_valid;
	assign q_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (take && q_cmd.action == ACT_LOAD) begin
			xs[q_cmd.entry] <= q_cmd.x;
			ys[q_cmd.entry] <= q_cmd.y;
			zs[q_cmd.entry] <= q_cmd.z;
		end
		x_s1 <= xs[ptr_q[IdxBits-1:0]];
		y_s1 <= ys[ptr_q[IdxBits-1:0]];
		z_s1 <= zs[ptr_q[IdxBits-1:0]];
		// marks are cleared one entry per cycle, after reset and on a batch clear
		if (state_q == ST_CLEAR) used_mem[ptr_q[IdxBits-1:0]] <= 1'b0;
		else if (state_q == ST_MARK && found_q) used_mem[best_i_q] <= 1'b1;
		u_s1 <= used_mem[ptr_q[IdxBits-1:0]];
	end

	always_comb begin
		dx = DiffBits'(x_s1) - DiffBits'(cmd_q.x);
		dy = DiffBits'(y_s1) - DiffBits'(cmd_q.y);
		dz = DiffBits'(z_s1) - DiffBits'(cmd_q.z);
		ax = dx[DiffBits-1] ? DiffBits'(-dx) : DiffBits'(dx);
		ay = dy[DiffBits-1] ? DiffBits'(-dy) : DiffBits'(dy);
		az = dz[DiffBits-1] ? DiffBits'(-dz) : DiffBits'(dz);
		dist_sum = DistBits'(sx_s2) + DistBits'(sy_s2) + DistBits'(sz_s2);
	end

	always_ff @(posedge clk) begin
		i_s1  <= ptr_q[IdxBits-1:0];
		i_s2  <= i_s1;
		u_s2  <= u_s1;
		sx_s2 <= ax * ax;
		sy_s2 <= ay * ay;
		sz_s2 <= az * az;
		if (take) cmd_q <= q_cmd;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.action)
						ACT_SNAP:  state_d = ST_SCAN;
						ACT_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: if (ptr_q == (IdxBits+1)'(MaxNodes - 1)) state_d = ST_IDLE;
			ST_SCAN:  if (ptr_q >= limit) state_d = ST_DRAIN;
			ST_DRAIN: if (!v_s1 && !v_s2) state_d = ST_MARK;
			ST_MARK:  state_d = ST_OUT;
			ST_OUT:   if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		out_valid  = (state_q == ST_OUT);
		out_index  = found_q ? best_i_q : '0;
		out_status = !found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			ptr_q    <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			found_q  <= 1'b0;
			best_q   <= '0;
			best_i_q <= '0;
		end else begin
			state_q <= state_d;
			v_s1 <= (state_q == ST_SCAN) && (ptr_q < limit);
			v_s2 <= v_s1;
			if (take) begin
				ptr_q   <= '0;
				found_q <= 1'b0;
			end else if (state_q == ST_CLEAR || (state_q == ST_SCAN && ptr_q < limit)) begin
				ptr_q <= ptr_q + 1'b1;
			end
			// strict less keeps the lowest index on a tie
			if (v_s2 && !u_s2 && (!found_q || dist_sum < best_q)) begin
				found_q  <= 1'b1;
				best_q   <= dist_sum;
				best_i_q <= i_s2;
			end
		end
	end
endmodule
`default_nettype wire

[hdl/greedy_nearest_free_node_snap_core.sv]
// Top level of the nearest free node snap core.
// Loads, batch clears and snaps arrive on the slave stream; each snap returns one
// result on the master stream, other actions return nothing. After reset the back
// end clears the used marks, one entry per cycle, before it takes a command. A snap
// result passes through the command queue, one table read per node (counts above
// 1024 act as 1024), a three-stage distance pipeline and a state that marks the
// winner; the back end then holds until the result is taken. A two-entry command
// queue lets the front accept while a result waits.
`default_nettype none
module greedy_nearest_free_node_snap_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire [10:0]  cfg_wdata,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [1:0]   s_tuser,  // action
	input  wire [63:0]  s_tdata,  // entry_index[9:0], pos_x, pos_y, pos_z, zero pad
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic        m_tuser,  // status
	output logic [15:0] m_tdata   // node_index[9:0], zero pad
);
	import gnfs_pkg::*;

	logic [CountBits-1:0] count_q;
	cmd_t                 in_cmd, q_cmd;
	logic                 q_valid, q_ready;
	logic [IdxBits-1:0]   idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cfg_we) count_q <= cfg_wdata;
	end

	always_comb begin
		in_cmd.action = action_t'(s_tuser);
		in_cmd.entry  = s_tdata[9:0];
		in_cmd.x      = s_tdata[25:10];
		in_cmd.y      = s_tdata[41:26];
		in_cmd.z      = s_tdata[57:42];
	end

	gnfs_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	gnfs_back u_back (
		.clk(clk), .arst_n(arst_n), .node_count(count_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_index(idx), .out_status(m_tuser)
	);

	assign m_tdata = {6'd0, idx};
endmodule
`default_nettype wire

[tb/tb_greedy_nearest_free_node_snap_core.sv]
// Self-checking testbench for the nearest free node snap core.
`default_nettype none
module tb_greedy_nearest_free_node_snap_core;
	import gnfs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LoadedNodes = 256;

	typedef struct packed {
		action_t            action;
		logic [9:0]         entry;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} req_t;

	typedef struct packed {
		logic [9:0] node;
		logic       status;
	} snap_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [10:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        m_tuser;
	logic [15:0] m_tdata;

	greedy_nearest_free_node_snap_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
	);

	// predictor state
	logic signed [15:0] tab_x [MaxNodes];
	logic signed [15:0] tab_y [MaxNodes];
	logic signed [15:0] tab_z [MaxNodes];
	bit                 taken [MaxNodes];
	int unsigned        active_nodes;

	req_t      pending_reqs [$];
	snap_res_t expected_snaps [$];
	int        errors = 0;
	bit        no_idle = 1'b0;
	bit        hold_sink = 1'b0;
	bit        in_acc = 1'b0;

	function automatic void add_req(req_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endfunction

	function automatic longint unsigned sq_dist(int i, req_t r);
		longint signed dx, dy, dz;
		dx = longint'(tab_x[i]) - longint'(r.x);
		dy = longint'(tab_y[i]) - longint'(r.y);
		dz = longint'(tab_z[i]) - longint'(r.z);
		return dx * dx + dy * dy + dz * dz;
	endfunction

	task automatic predict_snap(input req_t r);
		longint unsigned best_d, d;
		int best;
		snap_res_t res;
		best = -1;
		best_d = 0;
		case (r.action)
			ACT_LOAD: begin
				tab_x[r.entry] = r.x;
				tab_y[r.entry] = r.y;
				tab_z[r.entry] = r.z;
			end
			ACT_CLEAR: foreach (taken[i]) taken[i] = 1'b0;
			ACT_SNAP: begin
				for (int i = 0; i < active_nodes; i++) begin
					if (taken[i])
						continue;
					d = sq_dist(i, r);
					if (best < 0 || d < best_d) begin
						best = i;
						best_d = d;
					end
				end
				if (best >= 0) begin
					taken[best] = 1'b1;
					res.node = best[9:0];
					res.status = 1'b0;
				end else begin
					res.node = '0;
					res.status = 1'b1;
				end
				expected_snaps.insert(expected_snaps.size(), res);
			end
			default: ;
		endcase
	endtask

	initial forever #5 clk = ~clk;

	// input transfer seen at the rising edge, consumed by the driver
	always @(posedge clk)
		in_acc <= arst_n && s_tvalid && s_tready;

	// driver
	always @(negedge clk) begin
		req_t r;
		if (arst_n) begin
			if (in_acc)
				predict_snap(pending_reqs.pop_front());
			if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 20)) begin
				r = pending_reqs[0];
				s_tvalid <= 1'b1;
				s_tuser <= r.action;
				s_tdata <= {16'h0, r.z, r.y, r.x, r.entry};
			end else begin
				s_tvalid <= 1'b0;
			end
			m_tready <= !hold_sink && (no_idle || $urandom_range(99) >= 20);
		end
	end

	// monitor
	always @(posedge clk) begin
		snap_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_snaps.size() == 0) begin
				$display("%0t: unexpected result node=%0d status=%0d", $time, m_tdata[9:0],
					m_tuser);
				errors++;
			end else begin
				want = expected_snaps.pop_front();
				if (m_tdata[9:0] !== want.node || m_tuser !== want.status ||
						m_tdata[15:10] !== 6'd0) begin
					$display("%0t: mismatch expected node=%0d status=%0d, actual node=%0d status=%0d",
						$time, want.node, want.status, m_tdata[9:0], m_tuser);
					errors++;
				end
			end
		end
	end

	function automatic logic signed [15:0] rand_coord(int spread);
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(int'($urandom));
			default: return 16'($signed(16'($urandom_range(2 * spread))) - spread);
		endcase
	endfunction

	function automatic req_t mk(action_t a, int e, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z);
		req_t r;
		r.action = a;
		r.entry = e[9:0];
		r.x = x;
		r.y = y;
		r.z = z;
		return r;
	endfunction

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || s_tvalid || expected_snaps.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_count(int n);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n[10:0];
		active_nodes = (n > MaxNodes) ? MaxNodes : n;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_batch(int n, int snaps, int spread);
		int e;
		set_count(n);
		// a few reloads anywhere in the table
		for (int k = 0; k < 4; k++) begin
			e = $urandom_range(MaxNodes - 1);
			add_req(mk(ACT_LOAD, e, rand_coord(spread), rand_coord(spread),
				rand_coord(spread)));
		end
		add_req(mk(ACT_CLEAR, 0, 0, 0, 0));
		for (int i = 0; i < snaps; i++) begin
			if ($urandom_range(15) == 0)
				add_req(mk(ACT_NONE, $urandom, rand_coord(spread),
					rand_coord(spread), rand_coord(spread)));
			add_req(mk(ACT_SNAP, $urandom, rand_coord(spread),
				rand_coord(spread), rand_coord(spread)));
		end
		wait_idle();
	endtask

	initial begin
		int n;
		active_nodes = 0;
		foreach (taken[i])
			taken[i] = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// count zero: no free node, never touches the table
		add_req(mk(ACT_SNAP, 0, 0, 0, 0));
		// fill the low part of the table; extreme coords in the first entries
		add_req(mk(ACT_LOAD, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff));
		add_req(mk(ACT_LOAD, 1, 16'sh8000, 16'sh8000, 16'sh8000));
		add_req(mk(ACT_LOAD, 2, 0, 0, 0));
		add_req(mk(ACT_LOAD, 3, 0, 0, 0)); // tie with entry 2
		for (int i = 4; i < LoadedNodes; i++)
			add_req(mk(ACT_LOAD, i, rand_coord(2000), rand_coord(2000),
				rand_coord(2000)));
		add_req(mk(ACT_NONE, 10'h3ff, 16'sh7fff, 16'sh8000, -1));
		wait_idle();

		set_count(4);
		add_req(mk(ACT_SNAP, 0, 16'sh8000, 16'sh8000, 16'sh8000));
		add_req(mk(ACT_SNAP, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff));
		add_req(mk(ACT_SNAP, 0, 0, 0, 0));
		// reload a used entry: mark must stay
		add_req(mk(ACT_LOAD, 2, 0, 0, 0));
		add_req(mk(ACT_SNAP, 0, 0, 0, 0));
		add_req(mk(ACT_SNAP, 0, 0, 0, 0)); // all used
		add_req(mk(ACT_CLEAR, 0, 0, 0, 0));
		add_req(mk(ACT_SNAP, 10'h3ff, 16'sh7fff, 16'sh8000, 16'sh7fff));
		wait_idle();

		// scan over every loaded entry
		set_count(LoadedNodes);
		add_req(mk(ACT_CLEAR, 0, 0, 0, 0));
		add_req(mk(ACT_SNAP, 0, 1, -1, 1));
		add_req(mk(ACT_SNAP, 0, 16'sh8000, 16'sh7fff, 0));
		add_req(mk(ACT_SNAP, 0, 5, 5, 5));
		wait_idle();
		set_count(1);
		add_req(mk(ACT_SNAP, 0, 5, 5, 5));
		add_req(mk(ACT_SNAP, 0, 5, 5, 5));
		wait_idle();

		// long sink hold-off with a full sender
		no_idle = 1'b1;
		set_count(8);
		add_req(mk(ACT_CLEAR, 0, 0, 0, 0));
		for (int i = 0; i < 10; i++)
			add_req(mk(ACT_SNAP, 0, rand_coord(3000), rand_coord(3000),
				rand_coord(3000)));
		hold_sink = 1'b1;
		repeat (300) @(posedge clk);
		hold_sink = 1'b0;
		wait_idle();
		no_idle = 1'b0;

		// random batches, mostly small counts, some reloads
		for (int b = 0; b < 18; b++) begin
			if (b == 8)
				no_idle = 1'b1;
			if (b == 12)
				no_idle = 1'b0;
			if (b % 6 == 5)
				run_batch(LoadedNodes, 6, 100);
			else begin
				n = $urandom_range(1, 24);
				run_batch(n, $urandom_range(n / 2, n + 3), 100);
			end
		end

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
hdl/gnfs_pkg.sv
hdl/gnfs_front.sv
hdl/gnfs_back.sv
hdl/greedy_nearest_free_node_snap_core.sv
tb/tb_greedy_nearest_free_node_snap_core.sv
